// ===== hw/rtl/rs_pkg.sv =====
`timescale 1ns / 1ps

package rs_pkg;

  localparam int COORD_BITS = 16;

  localparam logic signed [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

  localparam int KIND_BITS = 3;
  localparam logic [KIND_BITS-1:0] KIND_WHOLE  = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_TOP    = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_LEFT   = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_BOTTOM = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_RIGHT  = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_NONE   = 3'd5;

  localparam int NUM_SLOTS = 4;
  localparam int SLOT_BITS = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t a_top;
    coord_t a_bottom;
    coord_t a_left;
    coord_t a_right;
    coord_t b_top;
    coord_t b_bottom;
    coord_t b_left;
    coord_t b_right;
  } rect_pair_t;

  typedef struct packed {
    coord_t               top;
    coord_t               bottom;
    coord_t               left;
    coord_t               right;
    logic [KIND_BITS-1:0] kind;
  } piece_t;

  // Slots hold top, left, bottom and right cuts in emission order.
  typedef struct packed {
    piece_t [NUM_SLOTS-1:0] slot;
    logic   [NUM_SLOTS-1:0] mask;
  } cut_set_t;

endpackage

// ===== hw/rtl/rs_in_if.sv =====
`timescale 1ns / 1ps

interface rs_in_if;
  logic            valid;
  logic            ready;
  rs_pkg::coord_t  a_top;
  rs_pkg::coord_t  a_bottom;
  rs_pkg::coord_t  a_left;
  rs_pkg::coord_t  a_right;
  rs_pkg::coord_t  b_top;
  rs_pkg::coord_t  b_bottom;
  rs_pkg::coord_t  b_left;
  rs_pkg::coord_t  b_right;

  modport source (
    output valid, a_top, a_bottom, a_left, a_right, b_top, b_bottom, b_left, b_right,
    input  ready
  );
  modport sink (
    input  valid, a_top, a_bottom, a_left, a_right, b_top, b_bottom, b_left, b_right,
    output ready
  );
endinterface

// ===== hw/rtl/rs_out_if.sv =====
`timescale 1ns / 1ps

interface rs_out_if;
  logic                         valid;
  logic                         ready;
  rs_pkg::coord_t               piece_top;
  rs_pkg::coord_t               piece_bottom;
  rs_pkg::coord_t               piece_left;
  rs_pkg::coord_t               piece_right;
  logic [rs_pkg::KIND_BITS-1:0] piece_kind;
  logic                         last_piece;

  modport source (
    output valid, piece_top, piece_bottom, piece_left, piece_right, piece_kind, last_piece,
    input  ready
  );
  modport sink (
    input  valid, piece_top, piece_bottom, piece_left, piece_right, piece_kind, last_piece,
    output ready
  );
endinterface

// ===== hw/rtl/rs_cut.sv =====
`timescale 1ns / 1ps

module rs_cut (
  input  rs_pkg::rect_pair_t rect_i,
  output rs_pkg::cut_set_t   set_o
);

  rs_pkg::coord_t at, ab, al, ar, bt, bb, bl, br;
  rs_pkg::coord_t at1, al1, ab1;
  logic           disjoint;
  logic           cut_top, cut_left, cut_bot, cut_right;

  assign at = rect_i.a_top;
  assign ab = rect_i.a_bottom;
  assign al = rect_i.a_left;
  assign ar = rect_i.a_right;
  assign bt = rect_i.b_top;
  assign bb = rect_i.b_bottom;
  assign bl = rect_i.b_left;
  assign br = rect_i.b_right;

  assign disjoint  = (at > bb) || (ab < bt) || (al > br) || (ar < bl);
  assign cut_top   = at < bt;
  assign cut_left  = al < bl;
  assign cut_bot   = ab > bb;
  assign cut_right = ar > br;

  // Each cut shrinks what is left of A for the pieces after it; the tests all use the original edges.
  assign at1 = cut_top  ? bt : at;
  assign al1 = cut_left ? bl : al;
  assign ab1 = cut_bot  ? bb : ab;

  always_comb begin
    set_o = '0;
    if (disjoint) begin
      set_o.slot[0] = '{top: at, bottom: ab, left: al, right: ar, kind: rs_pkg::KIND_WHOLE};
      set_o.mask    = 4'b0001;
    end else if (!(cut_top || cut_left || cut_bot || cut_right)) begin
      set_o.slot[0] = '{top: '0, bottom: '0, left: '0, right: '0, kind: rs_pkg::KIND_NONE};
      set_o.mask    = 4'b0001;
    end else begin
      set_o.slot[0] = '{top: at, bottom: bt - rs_pkg::COORD_ONE, left: al, right: ar,
                        kind: rs_pkg::KIND_TOP};
      set_o.slot[1] = '{top: at1, bottom: ab, left: al, right: bl - rs_pkg::COORD_ONE,
                        kind: rs_pkg::KIND_LEFT};
      set_o.slot[2] = '{top: bb + rs_pkg::COORD_ONE, bottom: ab, left: al1, right: ar,
                        kind: rs_pkg::KIND_BOTTOM};
      set_o.slot[3] = '{top: at1, bottom: ab1, left: br + rs_pkg::COORD_ONE, right: ar,
                        kind: rs_pkg::KIND_RIGHT};
      set_o.mask    = {cut_right, cut_bot, cut_left, cut_top};
    end
  end

endmodule

// ===== hw/rtl/rs_emit.sv =====
`timescale 1ns / 1ps

module rs_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             hold_v_i,
  input  rs_pkg::cut_set_t set_i,
  output logic             release_o,
  rs_out_if.source         out_ch
);

  logic [rs_pkg::SLOT_BITS-1:0] pos_r;
  logic [rs_pkg::NUM_SLOTS-1:0] cand;
  logic [rs_pkg::SLOT_BITS-1:0] sel;
  logic                         last;
  logic                         load;
  logic                         out_valid_r;
  rs_pkg::piece_t               out_piece_r;
  logic                         out_last_r;

  // Slots below the scan position have already been sent.
  assign cand = set_i.mask & ~((4'd1 << pos_r) - 4'd1);

  always_comb begin
    sel = '0;
    for (int i = rs_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        sel = rs_pkg::SLOT_BITS'(i);
      end
    end
  end

  assign last      = (cand >> sel) == 4'd1;
  assign load      = hold_v_i && (!out_valid_r || out_ch.ready);
  assign release_o = load && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        pos_r       <= last ? '0 : sel + 2'd1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_piece_r <= set_i.slot[sel];
      out_last_r  <= last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.piece_top    = out_piece_r.top;
  assign out_ch.piece_bottom = out_piece_r.bottom;
  assign out_ch.piece_left   = out_piece_r.left;
  assign out_ch.piece_right  = out_piece_r.right;
  assign out_ch.piece_kind   = out_piece_r.kind;
  assign out_ch.last_piece   = out_last_r;

  a_cand_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_i |-> (cand != '0))
    else $error("held word has no piece left to send");

  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !hold_v_i |-> (pos_r == '0))
    else $error("scan position not cleared while no word is held");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_piece_r.kind == rs_pkg::KIND_WHOLE ||
                     out_piece_r.kind == rs_pkg::KIND_NONE)) |-> out_last_r)
    else $error("whole or empty result not marked last");

  a_release_reset: assert property (@(posedge clk) disable iff (!rst_n)
    release_o |=> (pos_r == '0))
    else $error("scan position not rewound after the last piece");

endmodule

// ===== hw/rtl/rectangle_subtract_core.sv =====
`timescale 1ns / 1ps

// Subtracts rectangle B from rectangle A and sends the uncovered pieces of A in the
// order top, left, bottom, right, one piece per cycle while out_ch is ready, with
// last_piece set on the final one; a disjoint pair gives A whole and a fully
// covered A gives one empty result. A word is held in the input register while
// its 1 to 4 pieces move one by one into the output register, and the next word
// is taken in the cycle its last piece moves to the output. Pieces are cut from
// the word in the input register and registered in the output register.
module rectangle_subtract_core (
  input logic    clk,
  input logic    rst_n,
  rs_in_if.sink  in_ch,
  rs_out_if.source out_ch
);

  logic               hold_v_r;
  rs_pkg::rect_pair_t rect_r;
  rs_pkg::cut_set_t   cut_set;
  logic               release_w;

  assign in_ch.ready = !hold_v_r || release_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      hold_v_r <= 1'b1;
    end else if (release_w) begin
      hold_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      rect_r <= '{a_top: in_ch.a_top, a_bottom: in_ch.a_bottom,
                  a_left: in_ch.a_left, a_right: in_ch.a_right,
                  b_top: in_ch.b_top, b_bottom: in_ch.b_bottom,
                  b_left: in_ch.b_left, b_right: in_ch.b_right};
    end
  end

  rs_cut u_cut (
    .rect_i (rect_r),
    .set_o  (cut_set)
  );

  rs_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold_v_i  (hold_v_r),
    .set_i     (cut_set),
    .release_o (release_w),
    .out_ch    (out_ch)
  );

endmodule

// ===== dv/tb_rectangle_subtract_core.sv =====
`timescale 1ns / 1ps

module tb_rectangle_subtract_core;

  typedef struct packed {
    rs_pkg::coord_t               top;
    rs_pkg::coord_t               bottom;
    rs_pkg::coord_t               left;
    rs_pkg::coord_t               right;
    logic [rs_pkg::KIND_BITS-1:0] kind;
    logic                         last;
  } piece_exp_t;

  typedef struct {
    rs_pkg::rect_pair_t pair;
    bit                 drain;
  } pending_rect_t;

  logic clk = 1'b0;
  logic rst_n;

  rs_in_if  in_bus ();
  rs_out_if out_bus ();

  rectangle_subtract_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always #10 clk = ~clk;

  pending_rect_t rects_to_send [$];
  piece_exp_t    pieces_due [$];

  rs_pkg::rect_pair_t word_live;
  int send_gap = 0;
  int send_calm = 0;
  int recv_stall = 0;
  int recv_calm = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int words_taken = 0;
  int results_seen = 0;
  int input_wait_cycles = 0;
  int errors = 0;
  int kinds_seen [6];

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(15, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Cuts B out of A in the order top, left, bottom, right and queues the pieces.
  function automatic void subtract_rect(rs_pkg::rect_pair_t p);
    rs_pkg::coord_t t;
    rs_pkg::coord_t b;
    rs_pkg::coord_t l;
    piece_exp_t     cut [$];
    t = p.a_top;
    b = p.a_bottom;
    l = p.a_left;
    if (p.a_top > p.b_bottom || p.a_bottom < p.b_top ||
        p.a_left > p.b_right || p.a_right < p.b_left) begin
      cut.push_back('{p.a_top, p.a_bottom, p.a_left, p.a_right, rs_pkg::KIND_WHOLE, 1'b0});
    end else begin
      if (t < p.b_top) begin
        cut.push_back('{t, p.b_top - rs_pkg::COORD_ONE, l, p.a_right, rs_pkg::KIND_TOP, 1'b0});
        t = p.b_top;
      end
      if (l < p.b_left) begin
        cut.push_back('{t, b, l, p.b_left - rs_pkg::COORD_ONE, rs_pkg::KIND_LEFT, 1'b0});
        l = p.b_left;
      end
      if (b > p.b_bottom) begin
        cut.push_back('{p.b_bottom + rs_pkg::COORD_ONE, b, l, p.a_right,
                        rs_pkg::KIND_BOTTOM, 1'b0});
        b = p.b_bottom;
      end
      if (p.a_right > p.b_right) begin
        cut.push_back('{t, b, p.b_right + rs_pkg::COORD_ONE, p.a_right,
                        rs_pkg::KIND_RIGHT, 1'b0});
      end
    end
    if (cut.size() == 0) begin
      cut.push_back('{rs_pkg::coord_t'(0), rs_pkg::coord_t'(0), rs_pkg::coord_t'(0),
                      rs_pkg::coord_t'(0), rs_pkg::KIND_NONE, 1'b0});
    end
    cut[cut.size()-1].last = 1'b1;
    foreach (cut[i]) pieces_due.push_back(cut[i]);
  endfunction

  function automatic rs_pkg::coord_t clamp_coord(int v);
    if (v < -32768) return rs_pkg::coord_t'(-32768);
    if (v > 32767) return rs_pkg::coord_t'(32767);
    return rs_pkg::coord_t'(v);
  endfunction

  // One axis of a pair whose edges lie close together, so that most pairs overlap.
  task automatic near_axis(output rs_pkg::coord_t alo, output rs_pkg::coord_t ahi,
                           output rs_pkg::coord_t blo, output rs_pkg::coord_t bhi);
    int base;
    int a0;
    int a1;
    int b0;
    int b1;
    int sw;
    base = int'($urandom_range(0, 65535)) - 32768;
    if ($urandom_range(0, 9) == 0) base = ($urandom_range(0, 1) == 0) ? -32768 : 32755;
    a0 = base;
    a1 = base + int'($urandom_range(0, 12));
    b0 = a0 + int'($urandom_range(0, 16)) - 8;
    b1 = a1 + int'($urandom_range(0, 16)) - 8;
    if (b0 > b1 && $urandom_range(0, 19) != 0) begin
      sw = b0;
      b0 = b1;
      b1 = sw;
    end
    alo = clamp_coord(a0);
    ahi = clamp_coord(a1);
    blo = clamp_coord(b0);
    bhi = clamp_coord(b1);
  endtask

  task automatic add_rect(int at, int ab, int al, int ar, int bt, int bb, int bl, int br,
                          bit drain = 1'b0);
    pending_rect_t pr;
    pr.pair  = '{rs_pkg::coord_t'(at), rs_pkg::coord_t'(ab), rs_pkg::coord_t'(al),
                 rs_pkg::coord_t'(ar), rs_pkg::coord_t'(bt), rs_pkg::coord_t'(bb),
                 rs_pkg::coord_t'(bl), rs_pkg::coord_t'(br)};
    pr.drain = drain;
    rects_to_send.push_back(pr);
  endtask

  always @(posedge clk) begin : send_proc
    pending_rect_t nxt;
    logic          fire;
    if (!rst_n) begin
      in_bus.valid    <= 1'b0;
      in_bus.a_top    <= '0;
      in_bus.a_bottom <= '0;
      in_bus.a_left   <= '0;
      in_bus.a_right  <= '0;
      in_bus.b_top    <= '0;
      in_bus.b_bottom <= '0;
      in_bus.b_left   <= '0;
      in_bus.b_right  <= '0;
      send_gap = 0;
    end else begin
      fire = in_bus.valid && in_bus.ready;
      if (fire) begin
        subtract_rect(word_live);
        words_taken++;
      end
      if (in_bus.valid && !fire) begin
        input_wait_cycles++;
      end else if (send_gap > 0) begin
        send_gap--;
        in_bus.valid <= 1'b0;
      end else if (rects_to_send.size() > 0 &&
                   !(rects_to_send[0].drain && pieces_due.size() > 0)) begin
        nxt = rects_to_send.pop_front();
        word_live = nxt.pair;
        in_bus.a_top    <= nxt.pair.a_top;
        in_bus.a_bottom <= nxt.pair.a_bottom;
        in_bus.a_left   <= nxt.pair.a_left;
        in_bus.a_right  <= nxt.pair.a_right;
        in_bus.b_top    <= nxt.pair.b_top;
        in_bus.b_bottom <= nxt.pair.b_bottom;
        in_bus.b_left   <= nxt.pair.b_left;
        in_bus.b_right  <= nxt.pair.b_right;
        in_bus.valid    <= 1'b1;
        send_gap = pick_gap(send_calm);
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : take_proc
    piece_exp_t seen;
    piece_exp_t want;
    logic       nr;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        seen = '{out_bus.piece_top, out_bus.piece_bottom, out_bus.piece_left,
                 out_bus.piece_right, out_bus.piece_kind, out_bus.last_piece};
        results_seen++;
        if (pieces_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected word: t=%0d b=%0d l=%0d r=%0d kind=%0d last=%0d",
                     seen.top, seen.bottom, seen.left, seen.right, seen.kind, seen.last);
        end else begin
          want = pieces_due.pop_front();
          kinds_seen[want.kind]++;
          if (seen !== want) begin
            errors++;
            if (errors <= 10) begin
              $display("Mismatch on word %0d: expected t=%0d b=%0d l=%0d r=%0d kind=%0d last=%0d",
                       results_seen, want.top, want.bottom, want.left, want.right,
                       want.kind, want.last);
              $display("                  got      t=%0d b=%0d l=%0d r=%0d kind=%0d last=%0d",
                       seen.top, seen.bottom, seen.left, seen.right, seen.kind, seen.last);
            end
          end
        end
        recv_stall = pick_gap(recv_calm);
      end
      // A long hold-off once, while the sender keeps offering words, fills the block up.
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if (!hold_done && words_taken >= 40) begin
        hold_done = 1'b1;
        hold_left = 79;
        nr = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      out_bus.ready <= nr;
    end
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stim_proc
    rs_pkg::rect_pair_t p;
    rs_pkg::coord_t     sw;
    int                 mode;
    rst_n = 1'b0;

    add_rect(0, 9, 0, 9, 20, 29, 0, 9);
    add_rect(20, 29, 0, 9, 0, 9, 0, 9);
    add_rect(0, 9, 0, 9, 0, 9, 20, 29);
    add_rect(0, 9, 20, 29, 0, 9, 0, 9);
    add_rect(0, 9, 0, 9, 0, 9, 0, 9);
    add_rect(2, 5, 2, 5, 0, 9, 0, 9);
    add_rect(0, 9, 0, 9, 3, 6, 3, 6);
    add_rect(0, 9, 0, 9, 3, 9, 0, 9);
    add_rect(0, 9, 0, 9, 0, 9, 3, 9);
    add_rect(0, 9, 0, 9, 0, 6, 0, 9);
    add_rect(0, 9, 0, 9, 0, 9, 0, 6);
    add_rect(0, 9, 0, 9, 9, 9, 9, 9);
    add_rect(-32768, 32767, -32768, 32767, -32768, -32768, -32768, -32768);
    add_rect(-32768, 32767, -32768, 32767, 32767, 32767, 32767, 32767);
    add_rect(-32768, 32767, -32768, 32767, -1, 0, -1, 0);
    add_rect(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767);
    add_rect(32767, 32767, 32767, 32767, -32768, 32767, -32768, 32767);
    add_rect(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767);
    add_rect(9, 0, 9, 0, 3, 6, 3, 6);
    add_rect(5, 4, -5, 20, 0, 9, 0, 9);
    add_rect(0, 9, 0, 9, 6, 3, 6, 3);
    add_rect(9, 0, 9, 0, 6, 3, 6, 3);
    add_rect(-21846, 21845, -21846, 21845, -1, 0, -1, 0);

    for (int n = 0; n < 200; n++) begin
      mode = $urandom_range(0, 9);
      if (mode < 2) begin
        p = rs_pkg::rect_pair_t'({$urandom, $urandom, $urandom, $urandom});
        if (mode == 1) begin
          if (p.a_top > p.a_bottom) begin sw = p.a_top; p.a_top = p.a_bottom; p.a_bottom = sw; end
          if (p.a_left > p.a_right) begin sw = p.a_left; p.a_left = p.a_right; p.a_right = sw; end
          if (p.b_top > p.b_bottom) begin sw = p.b_top; p.b_top = p.b_bottom; p.b_bottom = sw; end
          if (p.b_left > p.b_right) begin sw = p.b_left; p.b_left = p.b_right; p.b_right = sw; end
        end
      end else begin
        near_axis(p.a_top, p.a_bottom, p.b_top, p.b_bottom);
        near_axis(p.a_left, p.a_right, p.b_left, p.b_right);
      end
      add_rect(p.a_top, p.a_bottom, p.a_left, p.a_right,
               p.b_top, p.b_bottom, p.b_left, p.b_right, n == 0 || n == 100);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (rects_to_send.size() > 0 || in_bus.valid || pieces_due.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d pieces from %0d rectangle pairs (whole %0d, top %0d, left %0d,",
             results_seen, words_taken, kinds_seen[rs_pkg::KIND_WHOLE],
             kinds_seen[rs_pkg::KIND_TOP], kinds_seen[rs_pkg::KIND_LEFT]);
    $display("bottom %0d, right %0d, covered %0d); input held off for %0d cycles.",
             kinds_seen[rs_pkg::KIND_BOTTOM], kinds_seen[rs_pkg::KIND_RIGHT],
             kinds_seen[rs_pkg::KIND_NONE], input_wait_cycles);
    if (errors == 0 && pieces_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rs_pkg.sv
hw/rtl/rs_in_if.sv
hw/rtl/rs_out_if.sv
hw/rtl/rs_cut.sv
hw/rtl/rs_emit.sv
hw/rtl/rectangle_subtract_core.sv
dv/tb_rectangle_subtract_core.sv
